FILE: rtl/tdr_pkg.sv
// Shared types and constants for the torus dimension-order route generator.
// No dependencies; imported by every module of the block.
package tdr_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;
  localparam int COORD_W      = 4;
  localparam int COUNT_W      = 5;
  localparam int HOP_CNT_W    = 5;
  localparam int HOP_LIMIT    = 30;
  localparam int COORD_SPAN   = 16;   // reach of a 4-bit coordinate
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

  localparam logic [COUNT_W-1:0] GRID_ROWS_RST = 5'd10;
  localparam logic [COUNT_W-1:0] GRID_COLS_RST = 5'd12;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_NORTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIX
  } walk_state_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
  } route_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] hop_row;
    logic [COORD_W-1:0] hop_col;
    dir_t               link_dir;
    logic               last_hop;
  } hop_t;

  // effective grid size after capping
  typedef struct packed {
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] cols;
  } grid_t;

  // request to the shared add / wrap unit
  typedef struct packed {
    logic [COUNT_W-1:0] operand;
    logic [COUNT_W-1:0] addend;
    logic [COUNT_W-1:0] count;
  } step_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] value;
    logic               in_range;
  } step_rsp_t;

endpackage

FILE: rtl/torus_dimension_order_route.sv
// Top level of the torus dimension-order route generator: config registers
// and the route walker. Depends on tdr_pkg, tdr_walk_ctrl and tdr_mod_step.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) takes one route request word:
//   network, start tile, end tile. Output channel (out_valid / out_ready /
//   out_data) gives one word per hop: the tile the hop leaves, the link
//   direction, and last_hop set on the final word of the route.
//   Grid size is set through the write port (cfg_we / cfg_index / cfg_data):
//   index 0 rows, index 1 columns. The user must write it only while the
//   block is idle; the block itself does not enforce this.
//   Hop words come from the shared add/wrap unit at one per cycle while the
//   receiver is ready and no wrap fix-up is pending. When the first step
//   along an axis starts from a coordinate outside the grid, each subtraction
//   of the count beyond the first takes its own pass through the fix-up state
//   before that hop word shows. Empty routes (start equals end, or end outside
//   the grid) give no words.
//   in_ready is high only while no route is being walked.
//   A stalled receiver freezes the walker; the pending word holds in the
//   output register and nothing is dropped.
//   Reset: rows 10, columns 12, walker idle, no output word pending.
module torus_dimension_order_route import tdr_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  route_req_t            in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hop_t                  out_data
);

  // grid counts are capped by the build limit and the 4-bit coordinate reach
  localparam logic [COUNT_W-1:0] ROW_CAP =
    COUNT_W'((MAX_ROWS < COORD_SPAN) ? MAX_ROWS : COORD_SPAN);
  localparam logic [COUNT_W-1:0] COL_CAP =
    COUNT_W'((MAX_COLS < COORD_SPAN) ? MAX_COLS : COORD_SPAN);

  logic [COUNT_W-1:0] grid_rows, grid_cols;
  grid_t              grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_ROWS_RST;
      grid_cols <= GRID_COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_ROWS: grid_rows <= cfg_data;
        CFG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero count puts every end tile outside, so all routes come out empty
  assign grid.rows = (grid_rows < ROW_CAP) ? grid_rows : ROW_CAP;
  assign grid.cols = (grid_cols < COL_CAP) ? grid_cols : COL_CAP;

  tdr_walk_ctrl u_walk (
    .clk       (clk),
    .rst       (rst),
    .grid      (grid),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/tdr_mod_step.sv
// Shared wrap unit: one add, then one conditional subtract of the count.
// Depends on tdr_pkg.
module tdr_mod_step import tdr_pkg::*; (
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] wrapped;

  // operand + addend never exceeds 30, so no carry out
  assign sum     = req.operand + req.addend;
  assign wrapped = (sum >= req.count) ? (sum - req.count) : sum;

  assign rsp.value    = wrapped;
  assign rsp.in_range = (wrapped < req.count);

endmodule

FILE: rtl/tdr_walk_ctrl.sv
// Route walker: sequencer, walker position, hop counter and output word register.
// Depends on tdr_pkg and tdr_mod_step.
module tdr_walk_ctrl import tdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  grid_t      grid,
  input  logic       in_valid,
  output logic       in_ready,
  input  route_req_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output hop_t       out_data
);

  walk_state_t state, state_next;

  logic [COUNT_W-1:0]   pos_row, pos_col;
  logic [COORD_W-1:0]   tgt_row, tgt_col;
  logic                 net;
  logic                 fix_row;
  logic [HOP_CNT_W-1:0] hop_cnt;

  step_req_t step_req;
  step_rsp_t step_rsp;

  logic accept, req_live;
  logic row_done, col_done, step_row;
  logic slot_free, last, arrive;
  logic walk_go, fix_go, show;
  logic [COUNT_W-1:0]   count_sel, new_row, new_col;
  logic [HOP_CNT_W-1:0] cnt_after;
  dir_t                 dir;

  tdr_mod_step u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  assign accept   = in_valid && in_ready;
  assign req_live = ({1'b0, in_data.end_row} < grid.rows) &&
                    ({1'b0, in_data.end_col} < grid.cols) &&
                    !((in_data.start_row == in_data.end_row) &&
                      (in_data.start_col == in_data.end_col));

  assign row_done  = (pos_row == {1'b0, tgt_row});
  assign col_done  = (pos_col == {1'b0, tgt_col});
  // net 0: east, then south. net 1: north, then west.
  assign step_row  = net ? !row_done : col_done;
  assign count_sel = step_row ? grid.rows : grid.cols;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    case ({net, step_row})
      2'b00:   dir = DIR_EAST;
      2'b01:   dir = DIR_SOUTH;
      2'b11:   dir = DIR_NORTH;
      default: dir = DIR_WEST;
    endcase
  end

  // shared unit operands
  always_comb begin
    if (state == ST_FIX) begin
      step_req.operand = fix_row ? pos_row : pos_col;
      step_req.addend  = '0;
      step_req.count   = fix_row ? grid.rows : grid.cols;
    end else begin
      step_req.operand = step_row ? pos_row : pos_col;
      step_req.addend  = net ? (count_sel - COUNT_W'(1)) : COUNT_W'(1);
      step_req.count   = count_sel;
    end
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    walk_go  = (state == ST_WALK) && slot_free;
    fix_go   = (state == ST_FIX);
    new_row  = pos_row;
    new_col  = pos_col;
    if ((walk_go && step_row) || (fix_go && fix_row)) begin
      new_row = step_rsp.value;
    end
    if ((walk_go && !step_row) || (fix_go && !fix_row)) begin
      new_col = step_rsp.value;
    end
    cnt_after = walk_go ? (hop_cnt + HOP_CNT_W'(1)) : hop_cnt;
    arrive    = (new_row == {1'b0, tgt_row}) && (new_col == {1'b0, tgt_col});
    last      = arrive || (cnt_after == HOP_CNT_W'(HOP_LIMIT));
    show      = (walk_go || fix_go) && step_rsp.in_range;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_live) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (slot_free) begin
          if (!step_rsp.in_range) state_next = ST_FIX;
          else if (last)          state_next = ST_IDLE;
        end
      end
      ST_FIX: begin
        if (step_rsp.in_range) state_next = last ? ST_IDLE : ST_WALK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      hop_cnt   <= '0;
    end else begin
      state <= state_next;
      if (show) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        hop_cnt <= '0;
      end else begin
        hop_cnt <= cnt_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      net     <= in_data.func;
      pos_row <= {1'b0, in_data.start_row};
      pos_col <= {1'b0, in_data.start_col};
      tgt_row <= in_data.end_row;
      tgt_col <= in_data.end_col;
    end else if (walk_go || fix_go) begin
      pos_row <= new_row;
      pos_col <= new_col;
    end
    if (walk_go) begin
      fix_row           <= step_row;
      out_data.hop_row  <= pos_row[COORD_W-1:0];
      out_data.hop_col  <= pos_col[COORD_W-1:0];
      out_data.link_dir <= dir;
      out_data.last_hop <= last;
    end else if (fix_go && step_rsp.in_range) begin
      out_data.last_hop <= last;
    end
  end

  // word held for wrap fix-up is never shown early
  a_fix_hidden: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> !out_valid)
    else $error("output shown while hop still wrapping");

  // walker never sits on its target
  a_walk_moves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !(row_done && col_done))
    else $error("walker active at target");

  // empty routes leave the block idle
  a_empty_route: assert property (@(posedge clk) disable iff (rst)
    (accept && !req_live) |=> (state == ST_IDLE) && !$rose(out_valid))
    else $error("empty route produced activity");

  a_hop_bound: assert property (@(posedge clk) disable iff (rst)
    hop_cnt <= HOP_CNT_W'(HOP_LIMIT))
    else $error("hop count past limit");

endmodule

FILE: sim/route_checker.sv
// Checker for torus_dimension_order_route: models the grid registers and the
// hop walk, and compares every hop word on the output channel. Uses tdr_pkg.
module route_checker import tdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  route_req_t            in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  hop_t                  out_data,
  output int                    errors,
  output int                    pending,
  output int                    hops_checked
);

  logic [COUNT_W-1:0] grid_rows;
  logic [COUNT_W-1:0] grid_cols;
  hop_t               hops_due[$];

  // Walks one request on the current grid and queues the hop words it gives.
  function automatic void plan_route(route_req_t r);
    int   rows;
    int   cols;
    int   row;
    int   col;
    int   n;
    hop_t h;
    // counts are capped by the grid maximum and by the 4-bit coordinate reach
    rows = int'(grid_rows);
    cols = int'(grid_cols);
    if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
    if (rows > COORD_SPAN) rows = COORD_SPAN;
    if (cols > MAX_COLS_DEF) cols = MAX_COLS_DEF;
    if (cols > COORD_SPAN) cols = COORD_SPAN;
    // end tile off the grid: empty route
    if (int'(r.end_row) >= rows || int'(r.end_col) >= cols) return;
    row = int'(r.start_row);
    col = int'(r.start_col);
    n = 0;
    while (n < HOP_LIMIT) begin
      h.hop_row  = row[COORD_W-1:0];
      h.hop_col  = col[COORD_W-1:0];
      h.last_hop = 1'b0;
      if (!r.func) begin
        if (col != int'(r.end_col)) begin
          h.link_dir = DIR_EAST;
          col = (col + 1) % cols;
        end else if (row != int'(r.end_row)) begin
          h.link_dir = DIR_SOUTH;
          row = (row + 1) % rows;
        end else begin
          break;
        end
      end else begin
        if (row != int'(r.end_row)) begin
          h.link_dir = DIR_NORTH;
          row = (row + rows - 1) % rows;
        end else if (col != int'(r.end_col)) begin
          h.link_dir = DIR_WEST;
          col = (col + cols - 1) % cols;
        end else begin
          break;
        end
      end
      hops_due = {hops_due, h};
      n++;
    end
    if (n > 0) hops_due[hops_due.size()-1].last_hop = 1'b1;
  endfunction

  always @(posedge clk) begin
    hop_t want;
    if (rst) begin
      grid_rows = GRID_ROWS_RST;
      grid_cols = GRID_COLS_RST;
      hops_due.delete();
      errors = 0;
      hops_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hops_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected hop word: row %0d col %0d dir %0d last %0b",
                   $time, out_data.hop_row, out_data.hop_col, out_data.link_dir,
                   out_data.last_hop);
        end else begin
          want = hops_due.pop_front();
          hops_checked++;
          if (out_data.hop_row !== want.hop_row || out_data.hop_col !== want.hop_col ||
              out_data.link_dir !== want.link_dir ||
              out_data.last_hop !== want.last_hop) begin
            errors++;
            $display("%0t: hop mismatch: expected row %0d col %0d dir %0d last %0b",
                     $time, want.hop_row, want.hop_col, want.link_dir, want.last_hop);
            $display("%0t:                 actual row %0d col %0d dir %0d last %0b",
                     $time, out_data.hop_row, out_data.hop_col, out_data.link_dir,
                     out_data.last_hop);
          end
        end
      end
      // request taken at this edge sees the grid as it was before the edge
      if (in_valid && in_ready) plan_route(in_data);
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_ROWS) grid_rows = cfg_data;
        else if (cfg_index == CFG_GRID_COLS) grid_cols = cfg_data;
      end
    end
    pending = hops_due.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the route generator bench: clock, reset, request and hop stimulus,
// verdict. Depends on tdr_pkg, torus_dimension_order_route and route_checker.
module testbench;
  import tdr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
  localparam int HOLD_CYCLES = 300;      // long receiver stall
  localparam int SETTLE      = 20;       // covers empty routes and wrap-in cycles

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRID_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  route_req_t            in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  hop_t                  out_data;

  int errors;
  int pending;
  int hops_checked;

  int send_idle = 27;     // percent of cycles the sender holds back
  int recv_idle = 62;     // percent of cycles the receiver holds back
  bit hold_req  = 1'b0;   // asks the receiver for one long stall
  int routes_sent = 0;
  int grids_used  = 0;
  int cycles      = 0;

  torus_dimension_order_route uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  route_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .errors       (errors),
    .pending      (pending),
    .hops_checked (hops_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offers one request word; entered and left at a falling edge. Valid stays
  // up across back-to-back words, so each edge sees one assignment at most.
  task automatic send_route(input logic f, input logic [3:0] sr, input logic [3:0] sc,
                            input logic [3:0] er, input logic [3:0] ec);
    route_req_t r;
    r.func      = f;
    r.start_row = sr;
    r.start_col = sc;
    r.end_row   = er;
    r.end_col   = ec;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    routes_sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits for every predicted hop word, then lets the
  // walker finish any empty route before the grid may change.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Grid writes happen only with the block drained.
  task automatic set_grid(input logic [4:0] rows, input logic [4:0] cols);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= rows;
    @(negedge clk);
    cfg_index <= CFG_GRID_COLS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_we    <= 1'b0;
    grids_used++;
  endtask

  // Receiver: random back-pressure, plus one long stall on request.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Watchdog.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int         rows_eff;
    int         cols_eff;
    int         live;
    logic [4:0] rows_cfg;
    logic [4:0] cols_cfg;
    logic       f;
    logic [3:0] sr;
    logic [3:0] sc;
    logic [3:0] er;
    logic [3:0] ec;

    // synchronous reset, then start at a falling edge
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset grid 10 x 12.
    send_route(1'b0, 4'd0, 4'd0, 4'd9, 4'd11);    // full east then south
    send_route(1'b1, 4'd0, 4'd0, 4'd9, 4'd11);    // north and west both wrap
    send_route(1'b0, 4'd3, 4'd3, 4'd3, 4'd3);     // start equals end: empty
    send_route(1'b1, 4'd0, 4'd0, 4'd10, 4'd0);    // end row off the grid
    send_route(1'b0, 4'd0, 4'd0, 4'd0, 4'd12);    // end column off the grid
    send_route(1'b0, 4'd15, 4'd15, 4'd2, 4'd3);   // start off the grid
    send_route(1'b1, 4'd15, 4'd15, 4'd2, 4'd3);
    send_route(1'b1, 4'd4, 4'd7, 4'd4, 4'd2);     // west only
    send_route(1'b0, 4'd5, 4'd2, 4'd1, 4'd2);     // south only, wrapping
    send_route(1'b1, 4'd15, 4'd15, 4'd15, 4'd15); // end off the grid, equal tiles

    // Largest grid; 31 rows caps at 16. Longest routes give 30 hops.
    set_grid(5'd31, 5'd16);
    send_route(1'b0, 4'd0, 4'd0, 4'd15, 4'd15);
    send_route(1'b1, 4'd15, 4'd15, 4'd0, 4'd0);
    send_route(1'b1, 4'd0, 4'd0, 4'd15, 4'd15);
    send_route(1'b0, 4'd15, 4'd15, 4'd15, 4'd15);

    // Single tile: only off-grid starts give hops.
    set_grid(5'd1, 5'd1);
    send_route(1'b0, 4'd5, 4'd5, 4'd0, 4'd0);
    send_route(1'b1, 4'd5, 4'd5, 4'd0, 4'd0);
    send_route(1'b0, 4'd0, 4'd0, 4'd0, 4'd0);

    // Zero counts: every end lies off the grid.
    set_grid(5'd0, 5'd16);
    send_route(1'b0, 4'd0, 4'd0, 4'd0, 4'd0);
    send_route(1'b1, 4'd3, 4'd3, 4'd0, 4'd5);
    set_grid(5'd5, 5'd0);
    send_route(1'b0, 4'd1, 4'd1, 4'd0, 4'd0);

    // Random part: three idling regimes, four grids each.
    for (int phase = 0; phase < 3; phase++) begin
      for (int sub = 0; sub < 4; sub++) begin
        if (sub == 3) begin
          rows_cfg = 5'($urandom_range(17, 31));   // above the cap
          cols_cfg = 5'($urandom_range(1, 31));
        end else begin
          rows_cfg = 5'($urandom_range(1, 16));
          cols_cfg = 5'($urandom_range(1, 16));
        end
        set_grid(rows_cfg, cols_cfg);
        if (sub == 0) begin
          case (phase)
            0: begin send_idle = 27; recv_idle = 62; end
            1: begin send_idle = 62; recv_idle = 27; end
            default: begin send_idle = 0; recv_idle = 0; end
          endcase
        end
        // long receiver stall while requests keep coming: the walker fills
        // and the input backs up
        if (phase == 2 && sub == 0) hold_req = 1'b1;
        rows_eff = (rows_cfg > 16) ? 16 : int'(rows_cfg);
        cols_eff = (cols_cfg > 16) ? 16 : int'(cols_cfg);
        live = 0;
        while (live < 22) begin
          f = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 99) < 75) begin
            // well-formed: end inside the grid, start mostly inside too
            er = 4'($urandom_range(0, rows_eff - 1));
            ec = 4'($urandom_range(0, cols_eff - 1));
            if ($urandom_range(0, 99) < 80) begin
              sr = 4'($urandom_range(0, rows_eff - 1));
              sc = 4'($urandom_range(0, cols_eff - 1));
            end else begin
              sr = 4'($urandom_range(0, 15));
              sc = 4'($urandom_range(0, 15));
            end
          end else begin
            sr = 4'($urandom_range(0, 15));
            sc = 4'($urandom_range(0, 15));
            er = 4'($urandom_range(0, 15));
            ec = 4'($urandom_range(0, 15));
          end
          send_route(f, sr, sc, er, ec);
          // only routes that walk count toward the quota of this grid
          if (int'(er) < rows_eff && int'(ec) < cols_eff && (sr != er || sc != ec))
            live++;
        end
      end
    end

    drain();
    $display("Sent %0d route requests over %0d grid settings; checked %0d hop words.",
             routes_sent, grids_used, hops_checked);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
